// ----- rtl/day_number_to_calendar_date_core_macros.svh -----
// ----------------------------------------------------------------------------
// Day Number to Calendar Date Assertion Macros
// Shared concurrent assertion forms clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DAY_NUMBER_TO_CALENDAR_DATE_CORE_MACROS_SVH
`define DAY_NUMBER_TO_CALENDAR_DATE_CORE_MACROS_SVH

// Same-cycle implication.
`define DNCD_ASSERT_SAME(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define DNCD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/dncd_pkg.sv -----
// ----------------------------------------------------------------------------
// Day Number to Calendar Date Package
// Widths, scaled-integer divider constants and shared types of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dncd_pkg;

  localparam int DayBits   = 24;
  localparam int NumStages = 9;

  localparam logic [DayBits-1:0] CutoverReset = DayBits'(2299161);

  // Century correction: t = 4 * (a - 1867216) - 1, divided by 146097.
  localparam int TBits       = DayBits + 3;
  localparam int TMagBits    = DayBits + 2;
  localparam int CenturyBias = 4 * 1867216 + 1;
  localparam int AlphaDiv    = 146097;
  localparam int AlphaShift  = TMagBits + 18;
  localparam int AlphaBits   = TMagBits - 17;
  localparam int MulAlphaBits = AlphaShift - 17;
  localparam logic [63:0] MulAlphaWide =
    ((64'd1 << AlphaShift) + 64'(AlphaDiv) - 64'd1) / 64'(AlphaDiv);
  localparam logic [MulAlphaBits-1:0] MulAlpha = MulAlphaWide[MulAlphaBits-1:0];

  // Shifted day count b = a + 1524.
  localparam int BBits   = DayBits + 1;
  localparam int DayBias = 1524;

  // Year count c = (100 * b - 12210) / 36525.
  localparam int CNumBits = DayBits + 7;
  localparam int CNumBias = 12210;
  localparam int CDiv     = 36525;
  localparam int CShift   = CNumBits + 16;
  localparam int CBits    = CNumBits - 15;
  localparam int MulCBits = CShift - 15;
  localparam logic [63:0] MulCWide =
    ((64'd1 << CShift) + 64'(CDiv) - 64'd1) / 64'(CDiv);
  localparam logic [MulCBits-1:0] MulC = MulCWide[MulCBits-1:0];

  localparam int DBits = BBits + 1;

  // Day within the shifted year and month count e = 10000 * x / 306001.
  localparam int XBits    = 9;
  localparam int XMin     = 123;
  localparam int XMax     = 488;
  localparam int ENumBits = 23;
  localparam int EDiv     = 306001;
  localparam int EShift   = ENumBits + 19;
  localparam int EBits    = 4;
  localparam int MulEBits = EShift - 18;
  localparam logic [63:0] MulEWide =
    ((64'd1 << EShift) + 64'(EDiv) - 64'd1) / 64'(EDiv);
  localparam logic [MulEBits-1:0] MulE = MulEWide[MulEBits-1:0];

  localparam int YearBits     = 17;
  localparam int MonthBits    = 4;
  localparam int DomBits      = 5;
  localparam int YearCalcBits = CBits + 2;
  localparam int YearOffset   = 4715;
  localparam int MonthsPerYear = 12;

  typedef struct packed {
    logic [NumStages-1:0] valid;
    logic [NumStages-1:0] load;
  } dncd_pipe_t;

  // Day offset of the start of month count e, floor(30.6001 * e).
  function automatic logic [XBits-1:0] month_start(input logic [EBits-1:0] e);
    logic [XBits-1:0] s;
    unique case (e)
      4'd0:  s = XBits'((306001 * 0) / 10000);
      4'd1:  s = XBits'((306001 * 1) / 10000);
      4'd2:  s = XBits'((306001 * 2) / 10000);
      4'd3:  s = XBits'((306001 * 3) / 10000);
      4'd4:  s = XBits'((306001 * 4) / 10000);
      4'd5:  s = XBits'((306001 * 5) / 10000);
      4'd6:  s = XBits'((306001 * 6) / 10000);
      4'd7:  s = XBits'((306001 * 7) / 10000);
      4'd8:  s = XBits'((306001 * 8) / 10000);
      4'd9:  s = XBits'((306001 * 9) / 10000);
      4'd10: s = XBits'((306001 * 10) / 10000);
      4'd11: s = XBits'((306001 * 11) / 10000);
      4'd12: s = XBits'((306001 * 12) / 10000);
      4'd13: s = XBits'((306001 * 13) / 10000);
      4'd14: s = XBits'((306001 * 14) / 10000);
      4'd15: s = XBits'((306001 * 15) / 10000);
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/day_number_to_calendar_date_core.sv -----
// ----------------------------------------------------------------------------
// Day Number to Calendar Date Core
// Converts a Julian day number into year, month and day of month.
// ----------------------------------------------------------------------------
// An accepted request is registered in every stage before its result appears.
// One request per cycle while out_stall_i is low; a full stage holds while blocked.
// The three constant divisions are reciprocal multiplies, one stage each.
// Reset clears all stage valid bits and sets the cutover to day 2299161.
// ----------------------------------------------------------------------------
`default_nettype none

`include "day_number_to_calendar_date_core_macros.svh"

module day_number_to_calendar_date_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                gregorian_cutover_we_i,
  input  wire logic [dncd_pkg::DayBits-1:0]        gregorian_cutover_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [dncd_pkg::DayBits-1:0]        day_number_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [dncd_pkg::YearBits-1:0]     year_out_o,
  output logic [dncd_pkg::MonthBits-1:0]           month_out_o,
  output logic [dncd_pkg::DomBits-1:0]             day_of_month_o
);

  import dncd_pkg::*;

  localparam int ProdABits = TMagBits + MulAlphaBits;
  localparam int ProdCBits = CNumBits + MulCBits;
  localparam int ProdEBits = ENumBits + MulEBits;
  localparam int StX       = 5;

  dncd_pipe_t pipe;

  logic [DayBits-1:0] cutover_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutover_q <= CutoverReset;
    end else if (gregorian_cutover_we_i) begin
      cutover_q <= gregorian_cutover_i;
    end
  end

  dncd_pipe_ctrl u_pipe_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .pipe_o      (pipe)
  );

  // Stage 0: cutover compare and the century numerator.
  logic [DayBits-1:0]      a0_q;
  logic                    ge0_q, ge0_d;
  logic                    neg0_q, neg0_d;
  logic [TMagBits-1:0]     tmag0_q, tmag0_d;
  logic signed [TBits-1:0] t0;

  always_comb begin
    t0      = $signed({1'b0, day_number_i, 2'b00}) - TBits'(CenturyBias);
    neg0_d  = t0[TBits-1];
    tmag0_d = neg0_d ? TMagBits'(-t0) : TMagBits'(t0);
    ge0_d   = day_number_i >= cutover_q;
  end

  always_ff @(posedge clk_i) begin
    if (pipe.load[0]) begin
      a0_q    <= day_number_i;
      ge0_q   <= ge0_d;
      neg0_q  <= neg0_d;
      tmag0_q <= tmag0_d;
    end
  end

  // Stage 1: century count magnitude.
  logic [DayBits-1:0]   a1_q;
  logic                 ge1_q, neg1_q;
  logic [AlphaBits-1:0] amag1_q;
  logic [ProdABits-1:0] prod_a;

  assign prod_a = ProdABits'(tmag0_q) * ProdABits'(MulAlpha);

  always_ff @(posedge clk_i) begin
    if (pipe.load[1]) begin
      a1_q    <= a0_q;
      ge1_q   <= ge0_q;
      neg1_q  <= neg0_q;
      amag1_q <= prod_a[AlphaShift +: AlphaBits];
    end
  end

  // Stage 2: corrected and shifted day count.
  logic [AlphaBits-1:0] adj;
  logic [BBits-1:0]     b2_q, b2_d;

  always_comb begin
    adj = amag1_q - (amag1_q >> 2);
    if (!ge1_q) begin
      b2_d = BBits'(a1_q) + BBits'(DayBias);
    end else if (neg1_q) begin
      b2_d = BBits'(a1_q) + BBits'(DayBias + 1) - BBits'(adj);
    end else begin
      b2_d = BBits'(a1_q) + BBits'(DayBias + 1) + BBits'(adj);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe.load[2]) begin
      b2_q <= b2_d;
    end
  end

  // Stage 3: scaled year numerator.
  logic [BBits-1:0]    b3_q;
  logic [CNumBits-1:0] n3_q;
  logic [CNumBits:0]   n3_wide;

  assign n3_wide = (CNumBits+1)'(b2_q) * (CNumBits+1)'(100) - (CNumBits+1)'(CNumBias);

  always_ff @(posedge clk_i) begin
    if (pipe.load[3]) begin
      b3_q <= b2_q;
      n3_q <= n3_wide[CNumBits-1:0];
    end
  end

  // Stage 4: year count.
  logic [BBits-1:0]     b4_q;
  logic [CBits-1:0]     c4_q;
  logic [ProdCBits-1:0] prod_c;

  assign prod_c = ProdCBits'(n3_q) * ProdCBits'(MulC);

  always_ff @(posedge clk_i) begin
    if (pipe.load[4]) begin
      b4_q <= b3_q;
      c4_q <= prod_c[CShift +: CBits];
    end
  end

  // Stage 5: day within the shifted year.
  logic [CBits-1:0] c5_q;
  logic [XBits-1:0] x5_q;
  logic [DBits-1:0] d_val, x_wide;

  always_comb begin
    d_val  = DBits'(c4_q) * DBits'(365) + DBits'(c4_q >> 2);
    x_wide = DBits'(b4_q) - d_val;
  end

  always_ff @(posedge clk_i) begin
    if (pipe.load[5]) begin
      c5_q <= c4_q;
      x5_q <= x_wide[XBits-1:0];
    end
  end

  // Stage 6: scaled month numerator.
  logic [CBits-1:0]    c6_q;
  logic [XBits-1:0]    x6_q;
  logic [ENumBits-1:0] n6_q;

  always_ff @(posedge clk_i) begin
    if (pipe.load[6]) begin
      c6_q <= c5_q;
      x6_q <= x5_q;
      n6_q <= ENumBits'(x5_q) * ENumBits'(10000);
    end
  end

  // Stage 7: month count.
  logic [CBits-1:0]     c7_q;
  logic [XBits-1:0]     x7_q;
  logic [EBits-1:0]     e7_q;
  logic [ProdEBits-1:0] prod_e;

  assign prod_e = ProdEBits'(n6_q) * ProdEBits'(MulE);

  always_ff @(posedge clk_i) begin
    if (pipe.load[7]) begin
      c7_q <= c6_q;
      x7_q <= x6_q;
      e7_q <= prod_e[EShift +: EBits];
    end
  end

  // Stage 8: calendar fields.
  logic [MonthBits-1:0]           mon_raw, mon_d;
  logic [XBits-1:0]               dom_wide;
  logic signed [YearCalcBits-1:0] yr_base, yr_fix;
  logic signed [YearBits-1:0]     year_q;
  logic [MonthBits-1:0]           month_q;
  logic [DomBits-1:0]             dom_q;

  always_comb begin
    mon_raw  = MonthBits'(e7_q) - MonthBits'(1);
    mon_d    = (mon_raw > MonthBits'(MonthsPerYear)) ?
               mon_raw - MonthBits'(MonthsPerYear) : mon_raw;
    dom_wide = x7_q - month_start(e7_q);
    yr_base  = $signed({2'b00, c7_q}) - YearCalcBits'(YearOffset)
               - $signed(YearCalcBits'(mon_d > MonthBits'(2)));
    yr_fix   = (yr_base <= 0) ? yr_base - YearCalcBits'(1) : yr_base;
  end

  always_ff @(posedge clk_i) begin
    if (pipe.load[8]) begin
      year_q  <= yr_fix[YearBits-1:0];
      month_q <= mon_d;
      dom_q   <= dom_wide[DomBits-1:0];
    end
  end

  assign out_valid_o    = pipe.valid[NumStages-1];
  assign year_out_o     = year_q;
  assign month_out_o    = month_q;
  assign day_of_month_o = dom_q;

  `DNCD_ASSERT_SAME(a_month_range, out_valid_o,
                    month_out_o != '0 && month_out_o <= MonthBits'(MonthsPerYear),
                    "Month result is outside one to twelve.")
  `DNCD_ASSERT_SAME(a_dom_nonzero, out_valid_o, day_of_month_o != '0,
                    "Day of month result is zero.")
  `DNCD_ASSERT_SAME(a_x_range, pipe.valid[StX],
                    x5_q >= XBits'(XMin) && x5_q <= XBits'(XMax),
                    "Day within the shifted year is out of range.")
  `DNCD_ASSERT_NEXT(a_accept_enters, in_valid_i && !in_stall_o, pipe.valid[0],
                    "Accepted request did not enter the first stage.")

endmodule

`default_nettype wire

// ----- rtl/dncd_pipe_ctrl.sv -----
// ----------------------------------------------------------------------------
// Day Number to Calendar Date Pipeline Control
// Valid bits of the datapath stages and the per-stage load enables.
// ----------------------------------------------------------------------------
`default_nettype none

module dncd_pipe_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               out_stall_i,
  output logic                    in_stall_o,
  output dncd_pkg::dncd_pipe_t    pipe_o
);

  import dncd_pkg::*;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] load;

  always_comb begin
    load[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      load[i] = !valid_q[i] || load[i+1];
    end
  end

  always_comb begin
    valid_d[0] = in_valid_i;
    for (int i = 1; i < NumStages; i++) begin
      valid_d[i] = valid_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int i = 0; i < NumStages; i++) begin
        if (load[i]) begin
          valid_q[i] <= valid_d[i];
        end
      end
    end
  end

  assign in_stall_o   = !load[0];
  assign pipe_o.valid = valid_q;
  assign pipe_o.load  = load;

endmodule

`default_nettype wire

// ----- dv/tb_day_number_to_calendar_date_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Day Number to Calendar Date Core Testbench
// Sends Julian day numbers through the converter under several cutover
// settings, with random idling on both sides, a long output hold-off and
// drains between settings. Every returned date is checked against a fixed
// expected date or a cycle-free date calculation kept inside the bench.
// ----------------------------------------------------------------------------

module tb_day_number_to_calendar_date_core;

  import dncd_pkg::*;

  localparam int NumPhases     = 6;
  localparam int PhaseRequests = 180;
  localparam int QuietRequests = 100;
  localparam int HoldCycles    = 80;
  localparam int DrainCycles   = 20;
  localparam logic [DayBits-1:0] DayMax = {DayBits{1'b1}};

  typedef struct packed {
    logic signed [YearBits-1:0] year;
    logic [MonthBits-1:0]       month;
    logic [DomBits-1:0]         dom;
  } cal_date_t;

  typedef struct packed {
    logic [DayBits-1:0] cutover;
    logic [DayBits-1:0] day;
    logic               fixed_exp;
    int                 year;
    int                 month;
    int                 dom;
  } dir_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       gregorian_cutover_we_i;
  logic [DayBits-1:0]         gregorian_cutover_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [DayBits-1:0]         day_number_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [YearBits-1:0] year_out_o;
  logic [MonthBits-1:0]       month_out_o;
  logic [DomBits-1:0]         day_of_month_o;

  cal_date_t          pending_dates[$];
  logic [DayBits-1:0] cutover_model;
  int                 err_count;
  int                 dates_checked;
  int                 days_sent;
  int                 cutovers_used;
  bit                 long_hold_req;
  bit                 no_idle;

  dir_row_t dir_rows [20] = '{
    '{CutoverReset, 24'd0,       1'b1, -4713, 1,  1},
    '{CutoverReset, 24'd1721423, 1'b1, -1,    12, 31},
    '{CutoverReset, 24'd1721424, 1'b1, 1,     1,  1},
    '{CutoverReset, 24'd2299160, 1'b1, 1582,  10, 4},
    '{CutoverReset, 24'd2299161, 1'b1, 1582,  10, 15},
    '{CutoverReset, 24'd2451545, 1'b1, 2000,  1,  1},
    '{CutoverReset, DayMax,      1'b0, 0,     0,  0},
    '{CutoverReset, 24'd1867216, 1'b0, 0,     0,  0},
    '{CutoverReset, 24'd1867215, 1'b0, 0,     0,  0},
    '{CutoverReset, 24'd2451604, 1'b0, 0,     0,  0},
    '{CutoverReset, 24'd8388608, 1'b0, 0,     0,  0},
    '{24'd0,        24'd0,       1'b0, 0,     0,  0},
    '{24'd0,        24'd1,       1'b0, 0,     0,  0},
    '{24'd0,        DayMax,      1'b0, 0,     0,  0},
    '{DayMax,       DayMax,      1'b0, 0,     0,  0},
    '{DayMax,       24'd16777214, 1'b0, 0,    0,  0},
    '{DayMax,       24'd2451545, 1'b0, 0,     0,  0},
    '{24'd1867216,  24'd1867216, 1'b0, 0,     0,  0},
    '{24'd1867216,  24'd1867215, 1'b0, 0,     0,  0},
    '{24'd1867216,  24'd5592405, 1'b0, 0,     0,  0}
  };

  day_number_to_calendar_date_core DUT (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .gregorian_cutover_we_i (gregorian_cutover_we_i),
    .gregorian_cutover_i    (gregorian_cutover_i),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .day_number_i           (day_number_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .year_out_o             (year_out_o),
    .month_out_o            (month_out_o),
    .day_of_month_o         (day_of_month_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic cal_date_t calendar_date_of(input logic [DayBits-1:0] day);
    longint    a;
    longint    alpha;
    longint    b;
    longint    c;
    longint    d;
    longint    e;
    longint    dom;
    longint    mon;
    longint    yr;
    cal_date_t r;
    a = longint'(day);
    if (day >= cutover_model) begin
      alpha = (4 * (a - 1867216) - 1) / 146097;
      a = a + 1 + alpha - alpha / 4;
    end
    b = a + 1524;
    c = (64'sd6680 * 36525 + 100 * (b - 2439870) - 12210) / 36525;
    d = 365 * c + c / 4;
    e = (10000 * (b - d)) / 306001;
    dom = b - d - (306001 * e) / 10000;
    mon = e - 1;
    if (mon > 12) begin
      mon = mon - 12;
    end
    yr = c - 4715;
    if (mon > 2) begin
      yr = yr - 1;
    end
    if (yr <= 0) begin
      yr = yr - 1;
    end
    r.year  = yr[YearBits-1:0];
    r.month = mon[MonthBits-1:0];
    r.dom   = dom[DomBits-1:0];
    return r;
  endfunction

  function automatic logic [DayBits-1:0] random_day();
    longint v;
    case ($urandom_range(0, 5))
      0: v = longint'($urandom_range(0, DayMax));
      1: v = longint'(cutover_model) + $urandom_range(0, 800) - 400;
      2: v = longint'($urandom_range(0, 3000));
      3: v = longint'(1721424 + $urandom_range(0, 1600) - 800);
      4: v = longint'(2451545 + $urandom_range(0, 400000) - 200000);
      default: v = longint'(DayMax) - $urandom_range(0, 3000);
    endcase
    if (v < 0) begin
      v = 0;
    end else if (v > longint'(DayMax)) begin
      v = longint'(DayMax);
    end
    return v[DayBits-1:0];
  endfunction

  task automatic send_day(input logic [DayBits-1:0] day, input cal_date_t exp_date,
                          input bit gap_ok);
    int gap;
    if (gap_ok && !no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    day_number_i <= day;
    do @(posedge clk_i); while (in_stall_o);
    pending_dates.push_back(exp_date);
    days_sent++;
  endtask

  task automatic write_cutover(input logic [DayBits-1:0] value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    gregorian_cutover_we_i <= 1'b1;
    gregorian_cutover_i    <= value;
    @(negedge clk_i);
    gregorian_cutover_we_i <= 1'b0;
    cutover_model = value;
    cutovers_used++;
  endtask

  initial begin
    #5_000_000;
    $display("tb_day_number_to_calendar_date_core NOT OK");
    $finish;
  end

  initial begin
    int run_len;
    bit stall_val;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_hold_req) begin
        repeat (HoldCycles) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
        long_hold_req = 1'b0;
      end else begin
        run_len   = $urandom_range(1, 14);
        stall_val = !no_idle && ($urandom_range(0, 3) == 0);
        repeat (run_len) begin
          @(negedge clk_i);
          out_stall_i <= stall_val;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cal_date_t exp_date;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected date %0d-%0d-%0d", $time, year_out_o, month_out_o,
                 day_of_month_o);
        err_count++;
      end else begin
        exp_date = pending_dates.pop_front();
        dates_checked++;
        if (year_out_o !== exp_date.year) begin
          $display("%0t: year expected %0d actual %0d", $time, exp_date.year, year_out_o);
          err_count++;
        end
        if (month_out_o !== exp_date.month) begin
          $display("%0t: month expected %0d actual %0d", $time, exp_date.month,
                   month_out_o);
          err_count++;
        end
        if (day_of_month_o !== exp_date.dom) begin
          $display("%0t: day expected %0d actual %0d", $time, exp_date.dom,
                   day_of_month_o);
          err_count++;
        end
      end
    end
  end

  initial begin
    logic [DayBits-1:0] phase_cut [NumPhases];
    logic [DayBits-1:0] day;
    cal_date_t          exp_date;
    rst_ni                 = 1'b0;
    gregorian_cutover_we_i = 1'b0;
    gregorian_cutover_i    = '0;
    in_valid_i             = 1'b0;
    day_number_i           = '0;
    cutover_model          = CutoverReset;
    err_count              = 0;
    dates_checked          = 0;
    days_sent              = 0;
    cutovers_used          = 1;
    long_hold_req          = 1'b0;
    no_idle                = 1'b0;
    phase_cut = '{24'd0, DayMax, 24'd1867216, 24'd1000000, 24'd0, CutoverReset};
    phase_cut[4] = DayBits'($urandom_range(1, DayMax - 1));
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cutover != cutover_model) begin
        write_cutover(dir_rows[i].cutover);
      end
      if (dir_rows[i].fixed_exp) begin
        exp_date.year  = dir_rows[i].year[YearBits-1:0];
        exp_date.month = dir_rows[i].month[MonthBits-1:0];
        exp_date.dom   = dir_rows[i].dom[DomBits-1:0];
      end else begin
        exp_date = calendar_date_of(dir_rows[i].day);
      end
      send_day(dir_rows[i].day, exp_date, 1'b1);
    end

    for (int p = 0; p < NumPhases; p++) begin
      write_cutover(phase_cut[p]);
      for (int n = 0; n < PhaseRequests; n++) begin
        if (p == NumPhases - 1 && n == PhaseRequests - QuietRequests) begin
          no_idle = 1'b1;
        end
        if (p == 0 && n == 40) begin
          long_hold_req = 1'b1;
          while (long_hold_req) begin
            day = random_day();
            send_day(day, calendar_date_of(day), 1'b0);
          end
        end
        day = random_day();
        send_day(day, calendar_date_of(day), 1'b1);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Converted %0d day numbers under %0d cutover settings, %0d dates checked.",
             days_sent, cutovers_used, dates_checked);
    $display("Covered both calendar sides, the year-zero skip and field extremes.");
    if (err_count == 0) begin
      $display("tb_day_number_to_calendar_date_core OK");
    end else begin
      $display("tb_day_number_to_calendar_date_core NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/dncd_pkg.sv
rtl/dncd_pipe_ctrl.sv
rtl/day_number_to_calendar_date_core.sv
dv/tb_day_number_to_calendar_date_core.sv
